@@ src/hlc_pkg.sv @@
// Shared types, constants and the log2 table for the rectify, dB and lowpass block.
// Used by every module of the block; depends on nothing else.
package hlc_pkg;

  localparam int CH_W       = 6;
  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 23;
  localparam int POLE_W     = 16;
  localparam int NSTG_W     = 3;
  localparam int MAX_STAGES = 4;
  localparam int STG_W      = 2;
  localparam int MEM_W      = 48;
  localparam int MEM_DEPTH  = 256;
  localparam int ADDR_W     = 8;
  localparam int LG_W       = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LOG_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LP_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STAGES  = 2'd3;

  localparam logic [18:0] DB_PER_LOG2 = 19'd394566;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  localparam logic [MEM_W-1:0]   MEM_MAX   = '1;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [LEVEL_W-1:0] x;
  } q_item_t;

  typedef struct packed {
    logic              lp_en;
    logic [POLE_W-1:0] pole;
    logic [NSTG_W-1:0] stages;
  } lp_cfg_t;

  // log2(1+i/16) in Q.16, rounded
  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      5'd16:   v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/hlc_queue.sv @@
// Two-entry queue between the front and the back of the block.
// Depends on hlc_pkg for the entry type.
module hlc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hlc_pkg::q_item_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output hlc_pkg::q_item_t pop_data
);
  import hlc_pkg::*;

  q_item_t    ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule

@@ src/hlc_front.sv @@
// Front end: takes samples, rectifies them and forms the linear or dB value.
// Depends on hlc_pkg; feeds hlc_queue.
module hlc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           log_en,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hlc_pkg::CH_W-1:0]       in_ch,
  input  logic [hlc_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                           push,
  input  logic                           q_full,
  output hlc_pkg::q_item_t               push_data
);
  import hlc_pkg::*;

  logic               s1_vld_r, s1_vld_nxt;
  logic [CH_W-1:0]    s1_ch_r;
  logic [LG_W-1:0]    s1_lg_r;
  logic [LEVEL_W-1:0] s1_lin_r;
  logic               s1_log_r;

  logic [14:0] v, m;
  logic [3:0]  e;
  logic [13:0] f;
  logic [16:0] t0, t1, frac;
  logic [22:0] dprod;
  logic [LG_W-1:0] lg;
  logic [39:0] dbp;
  logic        acc;

  assign acc      = in_valid && in_ready;
  assign push     = s1_vld_r && !q_full;
  assign in_ready = !s1_vld_r || !q_full;

  // log2 of the clamped sample: leading one, normalise, table with interpolation
  always_comb begin
    v = (in_sample[14:0] == 15'd0) ? 15'd1 : in_sample[14:0];
    e = 4'd0;
    for (int b = 0; b < 15; b++) begin
      if (v[b]) begin
        e = 4'(b);
      end
    end
    m     = v << (4'd14 - e);
    f     = m[13:0];
    t0    = log2_tab({1'b0, f[13:10]});
    t1    = log2_tab({1'b0, f[13:10]} + 5'd1);
    dprod = {6'd0, t1 - t0} * {13'd0, f[9:0]};
    frac  = t0 + {4'd0, dprod[22:10]};
    lg    = {e, 16'd0} + {3'd0, frac};
  end

  assign dbp = {20'd0, s1_lg_r} * {21'd0, DB_PER_LOG2} + 40'd8388608;
  assign push_data.ch = s1_ch_r;
  assign push_data.x  = s1_log_r ? {7'd0, dbp[39:24]} : s1_lin_r;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (push) begin
      s1_vld_nxt = 1'b0;
    end
    if (acc) begin
      s1_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ch_r  <= in_ch;
      s1_lg_r  <= lg;
      s1_log_r <= log_en && !in_sample[15];
      s1_lin_r <= in_sample[15] ? '0 : {in_sample[14:0], 8'd0};
    end
  end

endmodule

@@ src/hlc_back.sv @@
// Back end: walks the lowpass cascade of one channel stage by stage, with each multiply
// in a state of its own, and holds the stage memory. Depends on hlc_pkg; fed by hlc_queue.
module hlc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hlc_pkg::lp_cfg_t              cfg,
  input  logic                          mem_clr,
  input  logic                          q_vld,
  input  hlc_pkg::q_item_t              q_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hlc_pkg::CH_W-1:0]      out_ch,
  output logic [hlc_pkg::LEVEL_W-1:0]   out_level
);
  import hlc_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_RD   = 9'b000000010,
    ST_MA   = 9'b000000100,
    ST_MB   = 9'b000001000,
    ST_ACC  = 9'b000010000,
    ST_TA   = 9'b000100000,
    ST_TB   = 9'b001000000,
    ST_TO   = 9'b010000000,
    ST_OUT  = 9'b100000000
  } st_t;

  st_t                st_r, st_nxt;
  logic [CH_W-1:0]    ch_r;
  logic [LEVEL_W-1:0] x_r, x_nxt;
  logic [NSTG_W-1:0]  j_r, j_nxt;
  logic [NSTG_W-1:0]  n;
  logic [MEM_W-1:0]   mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  logic [MEM_W-1:0]   rd_q_r;
  logic               rd_vld_r;
  logic [MEM_W-1:0]   m, acc_r, acc_sat;
  logic [39:0]        plo_r, phi_r;
  logic [40:0]        tlo_r, thi_r;
  logic [16:0]        g;
  logic [ADDR_W-1:0]  addr;
  logic [63:0]        psum;
  logic [48:0]        accw;
  logic [64:0]        t;
  logic [41:0]        o;
  logic [LEVEL_W-1:0] o_sat;
  logic               we;
  logic               out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]    out_ch_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_load;

  assign n    = (cfg.stages > NSTG_W'(MAX_STAGES)) ? NSTG_W'(MAX_STAGES) : cfg.stages;
  assign g    = 17'd65536 - {1'b0, cfg.pole};
  assign addr = {ch_r, j_r[STG_W-1:0]};
  assign m    = rd_vld_r ? rd_q_r : '0;
  assign pop  = (st_r == ST_IDLE) && q_vld;
  assign we   = (st_r == ST_ACC);

  assign out_load  = (st_r == ST_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_ch    = out_ch_r;
  assign out_level = out_level_r;

  always_comb begin
    psum    = {phi_r, 24'd0} + {24'd0, plo_r} + 64'd32768;
    accw    = {18'd0, x_r, 8'd0} + {1'b0, psum[63:16]};
    acc_sat = accw[48] ? MEM_MAX : accw[47:0];
    t       = {thi_r, 24'd0} + {24'd0, tlo_r};
    o       = {1'b0, t[64:24]} + {41'd0, t[23]};
    o_sat   = (o[41:23] != '0) ? LEVEL_MAX : o[22:0];
  end

  always_comb begin
    st_nxt        = st_r;
    x_nxt         = x_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (st_r)
      ST_IDLE: begin
        if (q_vld) begin
          x_nxt  = q_data.x;
          j_nxt  = '0;
          st_nxt = (cfg.lp_en && n != '0) ? ST_RD : ST_OUT;
        end
      end
      ST_RD:  st_nxt = ST_MA;
      ST_MA:  st_nxt = ST_MB;
      ST_MB:  st_nxt = ST_ACC;
      ST_ACC: st_nxt = ST_TA;
      ST_TA:  st_nxt = ST_TB;
      ST_TB:  st_nxt = ST_TO;
      ST_TO: begin
        x_nxt  = o_sat;
        j_nxt  = j_r + NSTG_W'(1);
        st_nxt = (j_nxt == n) ? ST_OUT : ST_RD;
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_clr) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    j_r <= j_nxt;
    if (pop) begin
      ch_r <= q_data.ch;
    end
    if (st_r == ST_RD) begin
      rd_vld_r <= vld_r[addr];
    end
    if (st_r == ST_MA) begin
      plo_r <= {24'd0, cfg.pole} * {16'd0, m[23:0]};
    end
    if (st_r == ST_MB) begin
      phi_r <= {24'd0, cfg.pole} * {16'd0, m[47:24]};
    end
    if (we) begin
      acc_r <= acc_sat;
    end
    if (st_r == ST_TA) begin
      tlo_r <= {24'd0, g} * {17'd0, acc_r[23:0]};
    end
    if (st_r == ST_TB) begin
      thi_r <= {24'd0, g} * {17'd0, acc_r[47:24]};
    end
    if (out_load) begin
      out_ch_r    <= ch_r;
      out_level_r <= x_r;
    end
  end

  // Stage memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= acc_sat;
    end
    rd_q_r <= mem[addr];
  end

endmodule

@@ src/halfwave_log_cascade_lowpass.sv @@
// Half-wave rectifier, optional dB compressor and per-channel cascaded lowpass.
// Samples pass the front's stage register and a two-entry queue; the back takes one item
// at a time and goes straight to output with the lowpass bypassed, else walks each stage
// through states RD, MA, MB, ACC, TA, TB and TO; it takes no new item until it is done.
// Synchronous active-low reset; stage memories read as zero after reset and
// after any write that changes the stage count. Depends on hlc_pkg and submodules.
module halfwave_log_cascade_lowpass (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [5:0] channel, [21:6] sample, [23:22] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [5:0] channel_out, [28:6] level, [31:29] zero
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import hlc_pkg::*;

  logic              log_en_r;
  logic              lp_en_r;
  logic [POLE_W-1:0] pole_r;
  logic [NSTG_W-1:0] stages_r;
  logic              mem_clr;
  lp_cfg_t           cfg;
  q_item_t           push_data, pop_data;
  logic              push, q_full, q_vld, pop;
  logic [CH_W-1:0]    o_ch;
  logic [LEVEL_W-1:0] o_level;

  assign mem_clr = cfg_wr_en && (cfg_index == REG_STAGES) &&
                   (cfg_wdata[NSTG_W-1:0] != stages_r);
  assign cfg.lp_en  = lp_en_r;
  assign cfg.pole   = pole_r;
  assign cfg.stages = stages_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_en_r <= 1'b0;
      lp_en_r  <= 1'b1;
      pole_r   <= 16'd55234;
      stages_r <= 3'd2;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LOG_EN: log_en_r <= cfg_wdata[0];
        REG_LP_EN:  lp_en_r  <= cfg_wdata[0];
        REG_POLE:   pole_r   <= cfg_wdata;
        REG_STAGES: stages_r <= cfg_wdata[NSTG_W-1:0];
        default:    ;
      endcase
    end
  end

  hlc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .log_en    (log_en_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_ch     (in_tdata[5:0]),
    .in_sample (in_tdata[21:6]),
    .push      (push),
    .q_full    (q_full),
    .push_data (push_data)
  );

  hlc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_vld),
    .pop_data  (pop_data)
  );

  hlc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .mem_clr   (mem_clr),
    .q_vld     (q_vld),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ch    (o_ch),
    .out_level (o_level)
  );

  assign out_tdata = {3'd0, o_level, o_ch};

endmodule

@@ test/hlc_checker.sv @@
// Checker for the rectify, dB and lowpass block: watches both streams, predicts each
// level from its own copy of the filter state and compares. Depends on hlc_pkg.
module hlc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import hlc_pkg::*;

  logic [MEM_W-1:0] filt_mem [MEM_DEPTH];
  logic             log_on;
  logic             lp_on;
  logic [15:0]      pole_q16;
  logic [2:0]       n_stages;
  q_item_t          level_queue [$];

  function automatic logic [22:0] db_level(input logic [15:0] v);
    int unsigned e, m, f, idx, rem, frac;
    longint unsigned lg, tab [17];
    tab = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
            42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
    e = 0;
    for (int b = 0; b <= 14; b++) if (v[b]) e = b;
    m = (v << (14 - e)) & 32'h7FFF;
    f = (m - 16384) & 32'h3FFF;
    idx = f >> 10;
    rem = f & 1023;
    frac = 32'(tab[idx] + (((tab[idx+1] - tab[idx]) * rem) >> 10));
    lg = (longint'(e) << 16) + frac;
    return 23'((lg * 394566 + (64'd1 << 23)) >> 24);
  endfunction

  assign pending = level_queue.size();

  always @(posedge clk) begin
    logic [15:0] raw;
    longint unsigned x, acc, t, o, g, mem;
    int n, base;
    q_item_t got, exp_item;
    if (!rst_n) begin
      foreach (filt_mem[i]) filt_mem[i] = '0;
      log_on = 1'b0; lp_on = 1'b1; pole_q16 = 16'd55234; n_stages = 3'd2;
      level_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LOG_EN: log_on = cfg_wdata[0];
          REG_LP_EN:  lp_on = cfg_wdata[0];
          REG_POLE:   pole_q16 = cfg_wdata;
          REG_STAGES: begin
            if (cfg_wdata[2:0] != n_stages) foreach (filt_mem[i]) filt_mem[i] = '0;
            n_stages = cfg_wdata[2:0];
          end
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        raw = in_tdata[21:6];
        if (raw[15]) x = 0;
        else if (log_on) x = 64'(db_level(raw == 0 ? 16'd1 : raw));
        else x = longint'(raw) << 8;
        if (lp_on) begin
          n = n_stages > MAX_STAGES ? MAX_STAGES : int'(n_stages);
          base = in_tdata[5:0] * MAX_STAGES;
          g = 64'(65536 - pole_q16);
          for (int j = 0; j < n; j++) begin
            mem = 64'(filt_mem[base+j]);
            acc = (x << 8) + ((pole_q16 * mem + 32768) >> 16);
            if (acc > 64'hFFFF_FFFF_FFFF) acc = 64'hFFFF_FFFF_FFFF;
            filt_mem[base+j] = acc[47:0];
            t = acc * g;
            o = (t >> 24) + ((t >> 23) & 1);
            if (o > 8388607) o = 8388607;
            x = o;
          end
        end
        exp_item.ch = in_tdata[5:0];
        exp_item.x = x[22:0];
        level_queue.push_back(exp_item);
      end
      if (out_tvalid && out_tready) begin
        got.ch = out_tdata[5:0];
        got.x = out_tdata[28:6];
        if (level_queue.size() == 0) begin
          $error("unexpected result ch=%0d level=%0d", got.ch, got.x);
          fail_count++;
        end else begin
          exp_item = level_queue.pop_front();
          if (got.ch != exp_item.ch) begin
            $error("channel_out expected %0d actual %0d", exp_item.ch, got.ch);
            fail_count++;
          end
          if (got.x != exp_item.x) begin
            $error("level expected %0d actual %0d", exp_item.x, got.x);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

@@ test/tb_top.sv @@
// Stimulus and verdict for the rectify, dB and lowpass block; runs directed and
// random phases over several settings. Depends on hlc_pkg and hlc_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hlc_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic        cfg_wr_en = 0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;
  int          sent;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  halfwave_log_cascade_lowpass DUT (.*);

  hlc_checker checker_i (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // Receiver stalls at random, with quiet stretches of full readiness.
  always @(posedge clk) begin
    if (sent % 400 < 100) out_tready <= 1;
    else out_tready <= gap_len() == 0;
  end

  // The valid line stays high between back-to-back requests; it drops for a gap and in drain().
  task automatic send_request(input logic [5:0] ch, input logic [15:0] s, input bit idle);
    int g;
    g = idle ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {2'b00, s, ch};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    logic [15:0] s;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 4))
        0: s = 16'($urandom_range(0, 65535));
        1: s = 16'($urandom_range(0, 40));
        2: s = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        default: s = 16'($urandom_range(0, 32767));
      endcase
      send_request(6'($urandom_range(0, 63)), s, sent % 300 >= 60);
    end
  endtask

  initial begin
    logic [15:0] poles [6];
    logic [2:0]  stg [6];
    poles = '{16'd55234, 16'd0, 16'hFFFF, 16'd1, 16'd30000, 16'd64000};
    stg = '{3'd2, 3'd0, 3'd4, 3'd7, 3'd1, 3'd3};
    sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed items at reset settings, then with dB on; the loop below covers stage counts 0 to 4 and 7.
    send_request(6'd0, 16'h7FFF, 1'b0);
    send_request(6'd0, 16'h8000, 1'b0);
    send_request(6'd63, 16'h0000, 1'b0);
    send_request(6'd63, 16'hFFFF, 1'b0);
    send_request(6'd5, 16'h0001, 1'b0);
    drain();
    write_reg(REG_LOG_EN, 16'd1);
    send_request(6'd1, 16'h0000, 1'b0);
    send_request(6'd1, 16'h0001, 1'b0);
    send_request(6'd2, 16'h7FFF, 1'b0);
    send_request(6'd2, 16'hAAAA, 1'b0);
    send_request(6'd3, 16'h5555, 1'b0);
    send_request(6'd3, 16'h0400, 1'b0);
    drain();
    for (int k = 0; k < 6; k++) begin
      write_reg(REG_LOG_EN, 16'(k % 2));
      write_reg(REG_LP_EN, 16'(k != 1));
      write_reg(REG_POLE, poles[k]);
      write_reg(REG_STAGES, 16'(stg[k]));
      send_request(6'(k), 16'h7FFF, 1'b0);
      send_request(6'(k), 16'h7FFF, 1'b0);
      random_phase(300);
      drain();
    end
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
